### hw/rtl/dmchp_pkg.sv
package dmchp_pkg;

	localparam int ADDR_W  = 32;
	localparam int CNT_W   = 32;
	localparam int TALLY_W = 48;
	localparam int CFG_W   = 16;
	localparam int DELTA_W = CFG_W + 1;

	typedef logic [ADDR_W-1:0]         addr_t;
	typedef logic [CNT_W-1:0]          cnt_t;
	typedef logic signed [TALLY_W-1:0] tally_t;
	typedef logic [CFG_W-1:0]          cfg_data_t;

	typedef enum logic {
		MODE_FETCH = 1'b0,
		MODE_DATA  = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		REG_MODE          = 2'd0,
		REG_FETCH_PENALTY = 2'd1,
		REG_LOAD_SAVING   = 2'd2,
		REG_LOAD_LOSS     = 2'd3
	} cfg_reg_t;

	localparam cfg_data_t RST_FETCH_PENALTY = 16'd50;
	localparam cfg_data_t RST_LOAD_SAVING   = 16'd143;
	localparam cfg_data_t RST_LOAD_LOSS     = 16'd393;
	localparam addr_t     RST_PREV_ADDR     = '1;

	localparam cnt_t   CNT_MAX   = '1;
	localparam tally_t TALLY_MAX = {1'b0, {(TALLY_W-1){1'b1}}};
	localparam tally_t TALLY_MIN = {1'b1, {(TALLY_W-1){1'b0}}};

endpackage

### hw/rtl/dmchp_ram.sv
module dmchp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old contents when the same entry is written in that cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/direct_mapped_cache_hit_profiler.sv
// Direct-mapped cache hit profiler.
// Input channel (in_valid/in_ready): one beat per access, carrying the byte
// address and the load flag. Output channel (out_valid/out_ready): one beat
// per input beat, in order, with the lookup outcome and the running hit and
// miss counts and signed cycle tally after that access.
// Configuration: cfg_we writes cfg_data into register cfg_index (mode, fetch
// miss penalty, load hit saving, load miss loss); write only while idle.
// Pipeline: the tag RAM read registers with the input beat in the compare
// stage, and compare and update fill the output register. Throughput: one
// access per cycle, sustained while the receiver keeps out_ready high, since
// the tag and valid of a line written by the previous access are forwarded.
// After reset the block sweeps the tag RAM to clear every line's valid bit,
// one line a cycle, all 2**INDEX_BITS lines; in_ready stays low meanwhile.
// When the receiver stalls, the result holds in the output register and one
// more access can wait in the compare stage; in_ready then drops.
module direct_mapped_cache_hit_profiler #(
	parameter int INDEX_BITS  = 1,
	parameter int OFFSET_BITS = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  dmchp_pkg::cfg_data_t    cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  dmchp_pkg::addr_t        address,
	input  logic                    is_load,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    looked_up,
	output logic                    hit,
	output dmchp_pkg::cnt_t         hit_count,
	output dmchp_pkg::cnt_t         miss_count,
	output dmchp_pkg::tally_t       cycle_tally
);

	localparam int DEPTH  = 1 << INDEX_BITS;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TAG_W  = dmchp_pkg::ADDR_W - OFFSET_BITS - INDEX_BITS;
	localparam int LINE_W = TAG_W + 1;

	// configuration registers
	dmchp_pkg::mode_t     mode_q;
	dmchp_pkg::cfg_data_t fetch_penalty_q;
	dmchp_pkg::cfg_data_t load_saving_q;
	dmchp_pkg::cfg_data_t load_loss_q;

	// profile state
	dmchp_pkg::addr_t  prev_addr_q;
	dmchp_pkg::cnt_t   hits_q;
	dmchp_pkg::cnt_t   misses_q;
	dmchp_pkg::tally_t tally_q;

	// valid-clear sweep
	logic             clr_busy_q;
	logic [IDX_W-1:0] clr_idx_q;

	// last line fill, forwarded past the RAM read
	logic             byp_valid_q;
	logic [IDX_W-1:0] byp_idx_q;
	logic [TAG_W-1:0] byp_tag_q;

	// compare stage
	logic             valid_s1;
	dmchp_pkg::addr_t addr_s1;
	logic             is_load_s1;

	// output register
	logic              valid_s2;
	logic              looked_s2;
	logic              hit_s2;
	dmchp_pkg::cnt_t   hits_s2;
	dmchp_pkg::cnt_t   misses_s2;
	dmchp_pkg::tally_t tally_s2;

	logic              in_accept;
	logic              adv_s1;
	logic [IDX_W-1:0]  rd_idx;
	logic [IDX_W-1:0]  idx_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [LINE_W-1:0] ram_rdata;
	logic [LINE_W-1:0] line_s1;
	logic              line_hit;
	logic              skip;
	logic              do_lookup;
	logic              lk_hit;
	logic              lk_miss;
	logic signed [dmchp_pkg::DELTA_W-1:0] delta;
	logic signed [dmchp_pkg::TALLY_W:0]   tally_sum;
	dmchp_pkg::tally_t tally_nxt;
	dmchp_pkg::cnt_t   hits_nxt;
	dmchp_pkg::cnt_t   misses_nxt;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [LINE_W-1:0] ram_wdata;

	assign in_accept = in_valid && in_ready;
	assign adv_s1    = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !clr_busy_q && (!valid_s1 || adv_s1);

	assign rd_idx = IDX_W'((address >> OFFSET_BITS) & 32'(DEPTH - 1));
	assign idx_s1 = IDX_W'((addr_s1 >> OFFSET_BITS) & 32'(DEPTH - 1));
	assign tag_s1 = TAG_W'(addr_s1 >> (OFFSET_BITS + INDEX_BITS));

	dmchp_ram #(
		.WIDTH (LINE_W),
		.DEPTH (DEPTH)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_accept),
		.raddr (rd_idx),
		.rdata (ram_rdata)
	);

	always_comb begin
		// the RAM read misses a fill made at the same edge: take it from the bypass
		if (byp_valid_q && (byp_idx_q == idx_s1)) begin
			line_s1 = {1'b1, byp_tag_q};
		end else begin
			line_s1 = ram_rdata;
		end
		line_hit  = line_s1[LINE_W-1] && (line_s1[TAG_W-1:0] == tag_s1);
		skip      = (addr_s1 == prev_addr_q);
		do_lookup = (mode_q == dmchp_pkg::MODE_FETCH) || (!skip && is_load_s1);
		lk_hit    = do_lookup && line_hit;
		lk_miss   = do_lookup && !line_hit;

		delta = '0;
		if (mode_q == dmchp_pkg::MODE_FETCH) begin
			if (lk_miss) begin
				delta = $signed({1'b0, fetch_penalty_q});
			end
		end else begin
			if (lk_hit) begin
				delta = $signed({1'b0, load_saving_q});
			end else if (lk_miss) begin
				delta = -$signed({1'b0, load_loss_q});
			end
		end

		tally_sum = {tally_q[dmchp_pkg::TALLY_W-1], tally_q}
			+ {{(dmchp_pkg::TALLY_W + 1 - dmchp_pkg::DELTA_W){delta[dmchp_pkg::DELTA_W-1]}},
			   delta};
		if (tally_sum[dmchp_pkg::TALLY_W] != tally_sum[dmchp_pkg::TALLY_W-1]) begin
			tally_nxt = tally_sum[dmchp_pkg::TALLY_W] ? dmchp_pkg::TALLY_MIN
				: dmchp_pkg::TALLY_MAX;
		end else begin
			tally_nxt = tally_sum[dmchp_pkg::TALLY_W-1:0];
		end

		hits_nxt   = (lk_hit && (hits_q != dmchp_pkg::CNT_MAX)) ? hits_q + 1'b1 : hits_q;
		misses_nxt = (lk_miss && (misses_q != dmchp_pkg::CNT_MAX)) ? misses_q + 1'b1
			: misses_q;
	end

	always_comb begin
		if (clr_busy_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_idx_q;
			ram_wdata = '0;
		end else begin
			ram_we    = adv_s1 && lk_miss;
			ram_waddr = idx_s1;
			ram_wdata = {1'b1, tag_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= dmchp_pkg::MODE_FETCH;
			fetch_penalty_q <= dmchp_pkg::RST_FETCH_PENALTY;
			load_saving_q   <= dmchp_pkg::RST_LOAD_SAVING;
			load_loss_q     <= dmchp_pkg::RST_LOAD_LOSS;
		end else if (cfg_we) begin
			unique case (dmchp_pkg::cfg_reg_t'(cfg_index))
				dmchp_pkg::REG_MODE:          mode_q <= dmchp_pkg::mode_t'(cfg_data[0]);
				dmchp_pkg::REG_FETCH_PENALTY: fetch_penalty_q <= cfg_data;
				dmchp_pkg::REG_LOAD_SAVING:   load_saving_q <= cfg_data;
				dmchp_pkg::REG_LOAD_LOSS:     load_loss_q <= cfg_data;
				default:                      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == IDX_W'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			byp_valid_q <= 1'b0;
			prev_addr_q <= dmchp_pkg::RST_PREV_ADDR;
			hits_q      <= '0;
			misses_q    <= '0;
			tally_q     <= '0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end

			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end

			if (adv_s1) begin
				hits_q   <= hits_nxt;
				misses_q <= misses_nxt;
				tally_q  <= tally_nxt;
				if ((mode_q == dmchp_pkg::MODE_DATA) && !skip) begin
					prev_addr_q <= addr_s1;
				end
				if (lk_miss) begin
					byp_valid_q <= 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			addr_s1    <= address;
			is_load_s1 <= is_load;
		end
		if (adv_s1) begin
			looked_s2 <= do_lookup;
			hit_s2    <= lk_hit;
			hits_s2   <= hits_nxt;
			misses_s2 <= misses_nxt;
			tally_s2  <= tally_nxt;
			if (lk_miss) begin
				byp_idx_q <= idx_s1;
				byp_tag_q <= tag_s1;
			end
		end
	end

	assign out_valid   = valid_s2;
	assign looked_up   = looked_s2;
	assign hit         = hit_s2;
	assign hit_count   = hits_s2;
	assign miss_count  = misses_s2;
	assign cycle_tally = tally_s2;

endmodule

### hw/rtl/dmchp_checker.sv
module dmchp_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_we,
	input logic [1:0]           cfg_index,
	input dmchp_pkg::cfg_data_t cfg_data,
	input logic                 in_valid,
	input logic                 in_ready,
	input dmchp_pkg::addr_t     address,
	input logic                 is_load,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 looked_up,
	input logic                 hit,
	input dmchp_pkg::cnt_t      hit_count,
	input dmchp_pkg::cnt_t      miss_count,
	input dmchp_pkg::tally_t    cycle_tally
);

	logic out_beat;

	assign out_beat = out_valid && out_ready;

	// a hit is only reported for an access that was looked up
	hit_needs_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!hit || looked_up))
		else $error("hit reported without lookup");

	// a stalled result holds
	stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(hit_count)
			&& $stable(miss_count) && $stable(cycle_tally) && $stable(looked_up)
			&& $stable(hit)))
		else $error("stalled result changed");

	// back-to-back beats: a beat with no lookup leaves every total as it was
	no_lookup_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(out_beat ##1 (out_beat && !looked_up)) |->
			((hit_count == $past(hit_count)) && (miss_count == $past(miss_count))
			&& (cycle_tally == $past(cycle_tally))))
		else $error("totals changed without lookup");

	// back-to-back beats: a hit advances the hit count by one, saturating
	hit_advances_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_beat ##1 (out_beat && hit)) |->
			(((hit_count == $past(hit_count) + 1'b1)
			|| ((hit_count == dmchp_pkg::CNT_MAX) && ($past(hit_count) == dmchp_pkg::CNT_MAX)))
			&& (miss_count == $past(miss_count))))
		else $error("hit count did not advance");

	// back-to-back beats: a miss advances the miss count by one, saturating
	miss_advances_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_beat ##1 (out_beat && looked_up && !hit)) |->
			(((miss_count == $past(miss_count) + 1'b1)
			|| ((miss_count == dmchp_pkg::CNT_MAX) && ($past(miss_count) == dmchp_pkg::CNT_MAX)))
			&& (hit_count == $past(hit_count))))
		else $error("miss count did not advance");

endmodule

bind direct_mapped_cache_hit_profiler dmchp_checker u_dmchp_checker (.*);
